### hdl/jce_pkg.sv
// jce_pkg: widths, types and constants for the jet colormap entry block
// no dependencies; used by jet_colormap_entry_top
package jce_pkg;

  localparam int IDX_W          = 8;   // entry index width
  localparam int LEN_W          = 9;   // map length register width
  localparam int LVL_W          = 8;   // colour level width
  localparam int N_W            = 8;   // quarter length n, up to 128
  localparam int POS_W          = 11;  // signed profile position
  localparam int DIV_W          = 16;  // dividend / remainder width
  localparam int QBITS_PER_STG  = 2;   // quotient bits resolved per divider stage
  localparam int DIV_STAGES     = LVL_W / QBITS_PER_STG;
  localparam int NUM_COLOURS    = 3;
  localparam int MAX_LENGTH_DEF = 256;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

  // colour lane order
  localparam int C_RED   = 0;
  localparam int C_GREEN = 1;
  localparam int C_BLUE  = 2;

  typedef logic [LEN_W-1:0]        len_t;
  typedef logic [N_W-1:0]          quarter_t;
  typedef logic [LVL_W-1:0]        lvl_t;
  typedef logic [DIV_W-1:0]        rem_t;
  typedef logic signed [POS_W-1:0] pos_t;

endpackage

### hdl/jet_colormap_entry_top.sv
// jet_colormap_entry_top: pipelined jet colormap entry generator
// depends on jce_pkg
//
// One transaction is accepted per clock (start high, busy low); busy is only
// high while rst_n is asserted. Each result appears on the out_ ports for one
// cycle with out_strobe. Stage 1 registers the index and saturated length,
// stage 2 works out the quarter length and profile offset, stage 3 the
// profile numerator of each colour, divider stage 0 forms 255 times it, and
// four more divider stages resolve two quotient bits each. The receiver cannot
// stall the block. cfg_wdata is written to the map length on cfg_we and is
// used by transactions accepted from the next clock on; change it only while
// no transaction is in flight. Lengths above MAX_LENGTH saturate, and an
// index at or above the length returns zero colours with the out-of-range
// flag set.
module jet_colormap_entry_top #(
  parameter int MAX_LENGTH = jce_pkg::MAX_LENGTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [jce_pkg::IDX_W-1:0] in_entry_index,
  input  logic                      cfg_we,
  input  logic [jce_pkg::LEN_W-1:0] cfg_wdata,
  output logic                      out_strobe,
  output logic [jce_pkg::LVL_W-1:0] out_red_level,
  output logic [jce_pkg::LVL_W-1:0] out_green_level,
  output logic [jce_pkg::LVL_W-1:0] out_blue_level,
  output logic                      out_index_out_of_range
);

  localparam int LW      = jce_pkg::LEN_W;
  localparam int NW      = jce_pkg::N_W;
  localparam int DW      = jce_pkg::DIV_W;
  localparam int QW      = jce_pkg::LVL_W;
  localparam int QPS     = jce_pkg::QBITS_PER_STG;
  localparam int DS      = jce_pkg::DIV_STAGES;
  localparam int NC      = jce_pkg::NUM_COLOURS;
  localparam int LATENCY = 4 + DS;

  // configuration
  jce_pkg::len_t map_length_r;
  jce_pkg::len_t len_clamp;

  // stage 1: index and saturated length
  logic                      s1_v_r;
  logic [jce_pkg::IDX_W-1:0] s1_idx_r;
  jce_pkg::len_t             s1_len_r;

  // stage 2: n, g, range check
  logic                      s2_v_r;
  logic                      s2_oor_r;
  logic [jce_pkg::IDX_W-1:0] s2_idx_r;
  jce_pkg::quarter_t         s2_n_r;
  jce_pkg::quarter_t         s2_g_r;
  logic                      s2_oor_nxt;
  jce_pkg::quarter_t         s2_n_nxt;
  jce_pkg::quarter_t         s2_g_nxt;
  logic [LW:0]               len_plus3;
  logic [NW:0]               n_plus1;

  // stage 3: profile numerators
  logic                      s3_v_r;
  logic                      s3_oor_r;
  jce_pkg::quarter_t         s3_n_r;
  jce_pkg::quarter_t         s3_num_r [NC];
  jce_pkg::quarter_t         s3_num_nxt [NC];
  jce_pkg::pos_t             base_pos;
  jce_pkg::pos_t             pos [NC];
  jce_pkg::pos_t             n_pos;
  jce_pkg::pos_t             rise_end;
  jce_pkg::pos_t             hold_end;
  jce_pkg::pos_t             fall_end;

  // stage 0 of the divider array holds 255*num, stages 1..DS the long division
  logic                      pr_v_r   [DS+1];
  logic                      pr_oor_r [DS+1];
  jce_pkg::quarter_t         pr_n_r   [DS+1];
  jce_pkg::rem_t             pr_rem_r [DS+1][NC];
  jce_pkg::lvl_t             pr_q_r   [DS+1][NC];
  jce_pkg::rem_t             pr_rem_nxt [DS+1][NC];
  jce_pkg::lvl_t             pr_q_nxt   [DS+1][NC];

  logic accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_length_r <= jce_pkg::LEN_RESET;
    end else if (cfg_we) begin
      map_length_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (int'(map_length_r) > MAX_LENGTH) begin
      len_clamp = LW'(MAX_LENGTH);
    end else begin
      len_clamp = map_length_r;
    end
  end

  // stage 2 logic
  always_comb begin
    len_plus3  = {1'b0, s1_len_r} + (LW+1)'(3);
    s2_n_nxt   = NW'(len_plus3 >> 2);
    n_plus1    = {1'b0, s2_n_nxt} + (NW+1)'(1);
    s2_g_nxt   = NW'(n_plus1 >> 1) - NW'(s1_len_r[1:0] == 2'd1);
    s2_oor_nxt = {1'b0, s1_idx_r} >= s1_len_r;
  end

  // stage 3 logic: trapezoid profile numerator for each colour
  always_comb begin
    n_pos    = jce_pkg::pos_t'(s2_n_r);
    base_pos = jce_pkg::pos_t'(s2_idx_r) - jce_pkg::pos_t'(s2_g_r);
    rise_end = n_pos;
    hold_end = (n_pos <<< 1) - jce_pkg::pos_t'(1);
    fall_end = (n_pos <<< 1) + n_pos - jce_pkg::pos_t'(1);
    pos[jce_pkg::C_RED]   = base_pos - n_pos;
    pos[jce_pkg::C_GREEN] = base_pos;
    pos[jce_pkg::C_BLUE]  = base_pos + n_pos;
    for (int c = 0; c < NC; c++) begin
      if (pos[c] < jce_pkg::pos_t'(0) || pos[c] >= fall_end) begin
        s3_num_nxt[c] = '0;
      end else if (pos[c] < rise_end) begin
        s3_num_nxt[c] = NW'(pos[c] + jce_pkg::pos_t'(1));
      end else if (pos[c] < hold_end) begin
        s3_num_nxt[c] = s2_n_r;
      end else begin
        s3_num_nxt[c] = NW'(fall_end - pos[c]);
      end
    end
  end

  // dividend 255*num and restoring division, two quotient bits per stage
  always_comb begin
    jce_pkg::rem_t rem;
    jce_pkg::lvl_t q;
    jce_pkg::rem_t dsr;
    for (int c = 0; c < NC; c++) begin
      pr_rem_nxt[0][c] = (DW'(s3_num_r[c]) << QW) - DW'(s3_num_r[c]);
      pr_q_nxt[0][c]   = '0;
    end
    for (int d = 0; d < DS; d++) begin
      for (int c = 0; c < NC; c++) begin
        rem = pr_rem_r[d][c];
        q   = pr_q_r[d][c];
        for (int j = 0; j < QPS; j++) begin
          dsr = DW'(pr_n_r[d]) << (QW - 1 - QPS * d - j);
          if (rem >= dsr) begin
            rem = rem - dsr;
            q[QW - 1 - QPS * d - j] = 1'b1;
          end
        end
        pr_rem_nxt[d+1][c] = rem;
        pr_q_nxt[d+1][c]   = q;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      for (int d = 0; d <= DS; d++) begin
        pr_v_r[d] <= 1'b0;
      end
    end else begin
      s1_v_r    <= accept;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      pr_v_r[0] <= s3_v_r;
      for (int d = 0; d < DS; d++) begin
        pr_v_r[d+1] <= pr_v_r[d];
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_idx_r    <= in_entry_index;
    s1_len_r    <= len_clamp;
    s2_idx_r    <= s1_idx_r;
    s2_oor_r    <= s2_oor_nxt;
    s2_n_r      <= s2_n_nxt;
    s2_g_r      <= s2_g_nxt;
    s3_oor_r    <= s2_oor_r;
    s3_n_r      <= s2_n_r;
    s3_num_r    <= s3_num_nxt;
    pr_oor_r[0] <= s3_oor_r;
    pr_n_r[0]   <= s3_n_r;
    for (int d = 0; d < DS; d++) begin
      pr_oor_r[d+1] <= pr_oor_r[d];
      pr_n_r[d+1]   <= pr_n_r[d];
    end
    pr_rem_r <= pr_rem_nxt;
    pr_q_r   <= pr_q_nxt;
  end

  // out of range forces black
  assign out_strobe             = pr_v_r[DS];
  assign out_index_out_of_range = pr_oor_r[DS];
  assign out_red_level   = pr_oor_r[DS] ? '0 : pr_q_r[DS][jce_pkg::C_RED];
  assign out_green_level = pr_oor_r[DS] ? '0 : pr_q_r[DS][jce_pkg::C_GREEN];
  assign out_blue_level  = pr_oor_r[DS] ? '0 : pr_q_r[DS][jce_pkg::C_BLUE];

  // every accepted transaction comes out after the fixed latency
  a_accept_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("accepted transaction did not produce a result");

  // no result without a transaction behind it
  a_strobe_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result strobe without an accepted transaction");

  // profile numerator never exceeds n, so the quotient fits in a level
  a_num_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !s3_oor_r) |-> (s3_num_r[jce_pkg::C_RED] <= s3_n_r &&
                               s3_num_r[jce_pkg::C_GREEN] <= s3_n_r &&
                               s3_num_r[jce_pkg::C_BLUE] <= s3_n_r))
    else $error("profile numerator above quarter length");

  // division finished: every remainder below the divisor
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_index_out_of_range) |->
      (pr_rem_r[DS][jce_pkg::C_RED] < DW'(pr_n_r[DS]) &&
       pr_rem_r[DS][jce_pkg::C_GREEN] < DW'(pr_n_r[DS]) &&
       pr_rem_r[DS][jce_pkg::C_BLUE] < DW'(pr_n_r[DS])))
    else $error("divider remainder not reduced");

endmodule
